// ===== rtl/core/etmb_pkg.sv =====
// Shared types and constants of the transform matrix builder.
// Used by every module under rtl/core; depends on nothing.
package etmb_pkg;

  // quarter-wave sine polynomial, Q2.30
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [29:0] POLY_B  = 30'd688904866;
  localparam logic [26:0] POLY_C  = 27'd76016977;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // register stages of each section
  localparam int SIN_STAGES  = 5;
  localparam int ROT_STAGES  = 3;
  localparam int RCP_STAGES  = 6;
  localparam int ENT_STAGES  = 2;
  localparam int PIPE_DEPTH  = 1 + SIN_STAGES + ROT_STAGES + ENT_STAGES;

  // sine or cosine value, Q2.30 in [-1, 1]
  typedef logic signed [31:0] q30_t;
  // rotation term, Q3.30 in [-2, 2]
  typedef logic signed [32:0] rot_t;

  // reciprocal of a scale, Q10.16, with the saturated zero case flagged
  typedef struct packed {
    logic               zero;
    logic signed [25:0] val;
  } recip_t;

  // side word that travels along the pipeline
  typedef struct packed {
    logic             func;
    logic [2:0][15:0] scale;
    logic [2:0][31:0] pos;
  } side_t;

endpackage

// ===== rtl/core/etmb_sin_pipe.sv =====
// Five-stage quarter-wave sine polynomial evaluator.
// Depends on etmb_pkg for the polynomial constants and q30_t.
module etmb_sin_pipe
  import etmb_pkg::*;
(
  input  logic        clk,
  input  logic [30:0] z_i,
  input  logic        neg_i,
  output q30_t        sin_o
);

  logic [30:0] za_r, zb_r, zc_r;
  logic [30:0] z2a_r, z2b_r;
  logic [26:0] t1_r;
  logic [29:0] t2_r;
  logic [31:0] t3_r;
  logic        nega_r, negb_r, negc_r, negd_r;
  q30_t        sin_r;

  logic [61:0] pa, pd;
  logic [57:0] pb;
  logic [60:0] pc;
  logic [29:0] tb;
  logic [30:0] ta, clamp;

  // square, then Horner steps, each product truncated
  assign pa    = 62'(z_i) * 62'(z_i);
  assign pb    = 58'(POLY_C) * 58'(z2a_r);
  assign tb    = POLY_B - {3'b0, t1_r};
  assign pc    = 61'(z2b_r) * 61'(tb);
  assign ta    = POLY_A - {1'b0, t2_r};
  assign pd    = 62'(zc_r) * 62'(ta);
  assign clamp = (t3_r > {1'b0, Q30_ONE}) ? Q30_ONE : t3_r[30:0];

  // advance the stages every cycle
  always_ff @(posedge clk) begin
    za_r   <= z_i;
    z2a_r  <= pa[60:30];
    nega_r <= neg_i;
    zb_r   <= za_r;
    z2b_r  <= z2a_r;
    t1_r   <= pb[56:30];
    negb_r <= nega_r;
    zc_r   <= zb_r;
    t2_r   <= pc[59:30];
    negc_r <= negb_r;
    t3_r   <= pd[61:30];
    negd_r <= negc_r;
    sin_r  <= negd_r ? -$signed({1'b0, clamp}) : $signed({1'b0, clamp});
  end

  assign sin_o = sin_r;

endmodule

// ===== rtl/core/etmb_recip_pipe.sv =====
// Pipelined reciprocal 2^24 / scale, five quotient bits per stage.
// Depends on etmb_pkg for recip_t.
module etmb_recip_pipe
  import etmb_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] scale_i,
  output recip_t             recip_o
);

  localparam int DIV_STAGES = 5;
  localparam int BITS_STAGE = 5;

  logic [15:0] rem_r [DIV_STAGES];
  logic [24:0] quo_r [DIV_STAGES];
  logic [15:0] div_r [DIV_STAGES];
  logic        neg_r [DIV_STAGES];
  logic        zero_r[DIV_STAGES];
  recip_t      out_r;

  logic [16:0] mag;

  // run five restoring steps; the dividend holds one bit, at the top
  function automatic logic [40:0] div_step(input logic [15:0] rem, input logic [24:0] quo,
                                           input logic [15:0] dv, input logic first);
    logic [16:0] r17;
    logic [15:0] r;
    logic [24:0] q;
    r = rem;
    q = quo;
    for (int j = 0; j < BITS_STAGE; j++) begin
      r17 = {r, (first && (j == 0))};
      if (r17 >= {1'b0, dv}) begin
        r = 16'(r17 - {1'b0, dv});
        q = {q[23:0], 1'b1};
      end else begin
        r = r17[15:0];
        q = {q[23:0], 1'b0};
      end
    end
    return {r, q};
  endfunction

  assign mag = scale_i[15] ? 17'(-{scale_i[15], scale_i}) : {1'b0, scale_i};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [40:0] nxt;
    if (k == 0) begin : g_first
      assign nxt = div_step(16'd0, 25'd0, mag[15:0], 1'b1);
      always_ff @(posedge clk) begin
        div_r[k]  <= mag[15:0];
        neg_r[k]  <= scale_i[15];
        zero_r[k] <= (scale_i == 16'sd0);
      end
    end else begin : g_next
      assign nxt = div_step(rem_r[k-1], quo_r[k-1], div_r[k-1], 1'b0);
      always_ff @(posedge clk) begin
        div_r[k]  <= div_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      rem_r[k] <= nxt[40:25];
      quo_r[k] <= nxt[24:0];
    end
  end

  // apply the sign, quotient truncated toward zero
  always_ff @(posedge clk) begin
    out_r.zero <= zero_r[DIV_STAGES-1];
    out_r.val  <= neg_r[DIV_STAGES-1] ? -$signed({1'b0, quo_r[DIV_STAGES-1]})
                                      : $signed({1'b0, quo_r[DIV_STAGES-1]});
  end

  assign recip_o = out_r;

endmodule

// ===== rtl/core/etmb_rot_pipe.sv =====
// Three-stage rotation builder R = Ry * Rx * Rz from sines and cosines.
// Depends on etmb_pkg for q30_t and rot_t.
module etmb_rot_pipe
  import etmb_pkg::*;
(
  input  logic clk,
  input  q30_t s1_i,
  input  q30_t c1_i,
  input  q30_t s2_i,
  input  q30_t c2_i,
  input  q30_t s3_i,
  input  q30_t c3_i,
  output rot_t rot_o [9]
);

  q30_t c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r, c1s3_r, c2c3_r, s1s3_r, c2s1_r, c1c2_r;
  q30_t s2a_r, s3a_r;
  q30_t p0_r, p2_r, p3_r, p5_r;
  q30_t c1c3b_r, c3s1b_r, c1s3b_r, s1s3b_r, c2s3b_r, c2c3b_r, c2s1b_r, c1c2b_r, s2b_r;
  rot_t rot_r [9];

  // Q2.30 product, floored
  function automatic q30_t m30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[61:30];
  endfunction

  // first-level products
  always_ff @(posedge clk) begin
    c1c3_r <= m30(c1_i, c3_i);
    s1s2_r <= m30(s1_i, s2_i);
    c2s3_r <= m30(c2_i, s3_i);
    c1s2_r <= m30(c1_i, s2_i);
    c3s1_r <= m30(c3_i, s1_i);
    c1s3_r <= m30(c1_i, s3_i);
    c2c3_r <= m30(c2_i, c3_i);
    s1s3_r <= m30(s1_i, s3_i);
    c2s1_r <= m30(c2_i, s1_i);
    c1c2_r <= m30(c1_i, c2_i);
    s2a_r  <= s2_i;
    s3a_r  <= s3_i;
  end

  // second-level products, hold the rest
  always_ff @(posedge clk) begin
    p0_r    <= m30(s1s2_r, s3a_r);
    p2_r    <= m30(c1s2_r, s3a_r);
    p3_r    <= m30(c3s1_r, s2a_r);
    p5_r    <= m30(c1c3_r, s2a_r);
    c1c3b_r <= c1c3_r;
    c3s1b_r <= c3s1_r;
    c1s3b_r <= c1s3_r;
    s1s3b_r <= s1s3_r;
    c2s3b_r <= c2s3_r;
    c2c3b_r <= c2c3_r;
    c2s1b_r <= c2s1_r;
    c1c2b_r <= c1c2_r;
    s2b_r   <= s2a_r;
  end

  // sum into the nine terms
  always_ff @(posedge clk) begin
    rot_r[0] <= 33'(c1c3b_r) + 33'(p0_r);
    rot_r[1] <= 33'(c2s3b_r);
    rot_r[2] <= 33'(p2_r) - 33'(c3s1b_r);
    rot_r[3] <= 33'(p3_r) - 33'(c1s3b_r);
    rot_r[4] <= 33'(c2c3b_r);
    rot_r[5] <= 33'(p5_r) + 33'(s1s3b_r);
    rot_r[6] <= 33'(c2s1b_r);
    rot_r[7] <= -33'(s2b_r);
    rot_r[8] <= 33'(c1c2b_r);
  end

  assign rot_o = rot_r;

endmodule

// ===== rtl/core/etmb_entry_pipe.sv =====
// Two-stage matrix entry: rotation term times scale or reciprocal, saturated.
// Depends on etmb_pkg for rot_t and recip_t.
module etmb_entry_pipe
  import etmb_pkg::*;
(
  input  logic               clk,
  input  logic               func_i,
  input  rot_t               rot_i,
  input  logic signed [15:0] scale_i,
  input  recip_t             recip_i,
  output logic [31:0]        entry_o
);

  logic signed [63:0] prod_r;
  logic [31:0]        entry_r;

  logic signed [63:0] rot_w, pm, pn, pz, prod_nxt;
  logic signed [33:0] v;

  // model: rot*scale aligned to a shift of 30; normal: rot*recip, or rot*(2^31-1) for zero scale
  assign rot_w    = 64'(rot_i);
  assign pm       = rot_w * 64'(scale_i);
  assign pn       = rot_w * 64'(recip_i.val);
  assign pz       = (rot_w <<< 31) - rot_w;
  assign prod_nxt = !func_i ? (pm <<< 8) : (recip_i.zero ? pz : pn);

  assign v = prod_r[63:30];

  // hold the product, then floor and saturate
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (v > 34'sh0_7FFF_FFFF) begin
      entry_r <= 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      entry_r <= 32'h8000_0000;
    end else begin
      entry_r <= v[31:0];
    end
  end

  assign entry_o = entry_r;

endmodule

// ===== rtl/core/euler_trs_matrix_builder_core.sv =====
// Top level of the Y-X-Z scale/rotate/translate matrix builder.
// Depends on etmb_pkg, etmb_sin_pipe, etmb_recip_pipe, etmb_rot_pipe, etmb_entry_pipe.
//
// Usage:
//   Raise start with one object's func, angles, scales and positions on the
//   in_ ports; the word is taken at that edge (busy stays low, so a new word
//   may come in every cycle). func 0 gives the upper 3x4 of the model matrix,
//   func 1 the 3x3 normal matrix with a zero translation.
//   Each result appears on the out_ ports for one cycle with out_valid high,
//   after one input register, five sine stages, three rotation stages and
//   two entry stages. Throughput is one word per cycle; the reciprocal
//   divider runs alongside the sine stages at five quotient bits per stage.
//   Results come out in input order. The receiver takes every result in the
//   cycle it is shown. Reset clears every valid bit, so nothing in flight is
//   delivered after reset.
module euler_trs_matrix_builder_core
  import etmb_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_angle_x,
  input  logic [15:0] in_angle_y,
  input  logic [15:0] in_angle_z,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic signed [15:0] in_scale_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic        out_valid,
  output logic signed [31:0] out_col0_row0,
  output logic signed [31:0] out_col0_row1,
  output logic signed [31:0] out_col0_row2,
  output logic signed [31:0] out_col1_row0,
  output logic signed [31:0] out_col1_row1,
  output logic signed [31:0] out_col1_row2,
  output logic signed [31:0] out_col2_row0,
  output logic signed [31:0] out_col2_row1,
  output logic signed [31:0] out_col2_row2,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);

  // keep the top ANGLE_BITS bits of the 32-bit phase
  localparam logic [31:0] PH_MASK = ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam int          ENT_TAP = 1 + SIN_STAGES + ROT_STAGES - 1;

  logic [PIPE_DEPTH-1:0] vld_r;
  side_t                 side_r [PIPE_DEPTH];
  logic [30:0]           arg_r  [6];
  logic                  neg_r  [6];
  recip_t                rcpa_r [3];
  recip_t                rcpb_r [3];

  logic [31:0] ph      [6];
  q30_t        sin_w   [6];
  recip_t      rcp_w   [3];
  rot_t        rot_w   [9];
  logic [31:0] ent_w   [9];
  side_t       side_in;

  assign busy = 1'b0;

  // phases: sin(y), cos(y), sin(x), cos(x), sin(z), cos(z)
  assign ph[0] = {in_angle_y, 16'h0} & PH_MASK;
  assign ph[1] = ph[0] + QUARTER;
  assign ph[2] = {in_angle_x, 16'h0} & PH_MASK;
  assign ph[3] = ph[2] + QUARTER;
  assign ph[4] = {in_angle_z, 16'h0} & PH_MASK;
  assign ph[5] = ph[4] + QUARTER;

  assign side_in.func  = in_func;
  assign side_in.scale = {in_scale_z, in_scale_y, in_scale_x};
  assign side_in.pos   = {in_pos_z, in_pos_y, in_pos_x};

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  // fold each phase into a quarter wave and hold the side word
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      arg_r[i] <= ph[i][30] ? (Q30_ONE - {1'b0, ph[i][29:0]}) : {1'b0, ph[i][29:0]};
      neg_r[i] <= ph[i][31];
    end
    side_r[0] <= side_in;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_sin
    etmb_sin_pipe u_sin (
      .clk   (clk),
      .z_i   (arg_r[i]),
      .neg_i (neg_r[i]),
      .sin_o (sin_w[i])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_rcp
    etmb_recip_pipe u_rcp (
      .clk     (clk),
      .scale_i ($signed(side_r[0].scale[c])),
      .recip_o (rcp_w[c])
    );
  end

  // hold reciprocals until the rotation terms are ready
  always_ff @(posedge clk) begin
    rcpa_r <= rcp_w;
    rcpb_r <= rcpa_r;
  end

  etmb_rot_pipe u_rot (
    .clk   (clk),
    .s1_i  (sin_w[0]),
    .c1_i  (sin_w[1]),
    .s2_i  (sin_w[2]),
    .c2_i  (sin_w[3]),
    .s3_i  (sin_w[4]),
    .c3_i  (sin_w[5]),
    .rot_o (rot_w)
  );

  for (genvar i = 0; i < 9; i++) begin : g_ent
    etmb_entry_pipe u_ent (
      .clk     (clk),
      .func_i  (side_r[ENT_TAP].func),
      .rot_i   (rot_w[i]),
      .scale_i ($signed(side_r[ENT_TAP].scale[i/3])),
      .recip_i (rcpb_r[i/3]),
      .entry_o (ent_w[i])
    );
  end

  assign out_valid     = vld_r[PIPE_DEPTH-1];
  assign out_col0_row0 = ent_w[0];
  assign out_col0_row1 = ent_w[1];
  assign out_col0_row2 = ent_w[2];
  assign out_col1_row0 = ent_w[3];
  assign out_col1_row1 = ent_w[4];
  assign out_col1_row2 = ent_w[5];
  assign out_col2_row0 = ent_w[6];
  assign out_col2_row1 = ent_w[7];
  assign out_col2_row2 = ent_w[8];

  // drop translation for the normal matrix
  assign out_trans_x = side_r[PIPE_DEPTH-1].func ? '0 : side_r[PIPE_DEPTH-1].pos[0];
  assign out_trans_y = side_r[PIPE_DEPTH-1].func ? '0 : side_r[PIPE_DEPTH-1].pos[1];
  assign out_trans_z = side_r[PIPE_DEPTH-1].func ? '0 : side_r[PIPE_DEPTH-1].pos[2];

  // a taken word is delivered with out_valid high
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##11 out_valid)
    else $error("result missing after latency");

  // zero angles leave the off-diagonal terms col0_row1 and col1_row0 at zero
  a_ident_off: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_angle_x == 16'h0 && in_angle_y == 16'h0 && in_angle_z == 16'h0
    |-> ##11 out_col0_row1 == 32'sh0 && out_col1_row0 == 32'sh0)
    else $error("off-diagonal term nonzero for zero angles");

  // unit x scale and zero angles in the normal matrix give a unit col0_row0 entry
  a_unit_norm: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_func && in_scale_x == 16'sh0100 && in_angle_x == 16'h0 &&
    in_angle_y == 16'h0 && in_angle_z == 16'h0
    |-> ##11 out_col0_row0 == 32'sh0001_0000)
    else $error("reciprocal path wrong for unit scale");

endmodule
